// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ===== rtl/core/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// fba_pkg
// Shared codes, field widths and control structs of the frame allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int CFG_W      = 13;
	localparam int ADDR_W     = 32;
	localparam int USED_KB_W  = 15;
	localparam int PAGE_SHIFT = 12;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 56;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_INIT  = 2'd0;
	localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
	localparam logic [OP_W-1:0] OP_FREE  = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP   = 2'd3;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_FRAME = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

	// Configuration register indexes.
	localparam logic REG_FRAME_TOTAL = 1'b0;
	localparam logic REG_RESERVED    = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic            start;
		logic [OP_W-1:0] op;
		logic            sweep;
		logic            set_count;
		logic            scan;
		logic            free_wr;
		logic            load_out;
	} fba_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sweep_last;
		logic scan_found;
		logic scan_end;
		logic out_free;
	} fba_stat_t;

endpackage

// ===== rtl/core/frame_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_unit
// First-fit page-frame allocator over a one-bit-per-frame used map.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake            Contents
// s_*       in         s_tvalid / s_tready  request: opcode, byte address
// m_*       out        m_tvalid / m_tready  result: frame address, status, used KiB
// cfg_*     in         cfg_we               frame total, reserved frames
//
// Each request takes a walk through the controller. A free goes through the
// free state to the result, a no-operation straight to the result, an init
// sweeps every map word, and an allocation scans map words until it finds a
// free frame or reaches the end. The map memory reads one word and writes
// one per cycle. After reset a clearing pass zeroes the map before the
// first request is taken. A stalled result holds in the output register
// while the next request is accepted; a second result then waits in the
// controller until the register is free.
//
module frame_bitmap_allocator_unit #(
	parameter int MAX_FRAMES = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,

	// Request stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// Fields from bit 0: opcode [1:0], address [33:2], zero fill [39:34].
	input  logic [fba_pkg::IN_DATA_W-1:0]  s_tdata,

	// Result stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// Fields from bit 0: frame_address [31:0], status [33:32],
	// used_kb [48:34], zero fill [55:49].
	output logic [fba_pkg::OUT_DATA_W-1:0] m_tdata,

	// Configuration write port.
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [fba_pkg::CFG_W-1:0]      cfg_data
);

`include "assert_macros.svh"

	fba_pkg::fba_cmd_t  cmd;
	fba_pkg::fba_stat_t stat;

	// The controller sees only the opcode; the datapath takes the address.
	fba_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.opcode  (s_tdata[fba_pkg::OP_W-1:0]),
		.stat    (stat),
		.cmd     (cmd)
	);

	fba_datapath #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.address  (s_tdata[fba_pkg::OP_W +: fba_pkg::ADDR_W]),
		.cmd      (cmd),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// A result is only written into an output register that is empty or
	// being emptied in the same cycle.
	`ASSERT_IMPL(a_load_slot_free, clk, arst_n, cmd.load_out, !m_tvalid || m_tready)
	// Once a request transfers, the block is busy in the next cycle.
	`ASSERT_NEXT(a_accept_then_busy, clk, arst_n, s_tvalid && s_tready, !s_tready)
	// A new result only appears after the controller loaded one.
	`ASSERT_IMPL(a_valid_from_load, clk, arst_n, $rose(m_tvalid), $past(cmd.load_out))

endmodule

// ===== rtl/core/fba_ram.sv =====
// ----------------------------------------------------------------------------
// fba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module fba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 512,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/fba_ctrl.sv =====
// ----------------------------------------------------------------------------
// fba_ctrl
// Sequencer of the frame allocator: clearing pass, init sweep, allocation
// scan, free and result hand-off.
// ----------------------------------------------------------------------------
module fba_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [fba_pkg::OP_W-1:0] opcode,
	input  fba_pkg::fba_stat_t      stat,
	output fba_pkg::fba_cmd_t       cmd
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_SWEEP = 6'b000100,
		S_SCAN  = 6'b001000,
		S_FREE  = 6'b010000,
		S_RESP  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d       = state_q;
		s_tready      = 1'b0;
		cmd           = '0;
		cmd.op        = opcode;
		unique case (state_q)
			S_CLEAR: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					unique case (opcode)
						fba_pkg::OP_INIT:  state_d = S_SWEEP;
						fba_pkg::OP_ALLOC: state_d = S_SCAN;
						fba_pkg::OP_FREE:  state_d = S_FREE;
						fba_pkg::OP_NOP:   state_d = S_RESP;
						default:           state_d = S_RESP;
					endcase
				end
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				if (stat.sweep_last) begin
					cmd.set_count = 1'b1;
					state_d       = S_RESP;
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.scan_found || stat.scan_end) begin
					state_d = S_RESP;
				end
			end
			S_FREE: begin
				cmd.free_wr = 1'b1;
				state_d     = S_RESP;
			end
			S_RESP: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/fba_datapath.sv =====
// ----------------------------------------------------------------------------
// fba_datapath
// Used-frame map memory, word index and remaining-frame counters, used
// count, configuration registers and the output register.
// ----------------------------------------------------------------------------
module fba_datapath #(
	parameter int MAX_FRAMES = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic                           cfg_index,
	input  logic [fba_pkg::CFG_W-1:0]      cfg_data,
	input  logic [fba_pkg::ADDR_W-1:0]     address,
	input  fba_pkg::fba_cmd_t              cmd,
	output fba_pkg::fba_stat_t             stat,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [fba_pkg::OUT_DATA_W-1:0] m_tdata
);

	localparam int DEPTH = MAX_FRAMES / 8;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW    = $clog2(MAX_FRAMES + 1);
	localparam int CW    = (FW > fba_pkg::CFG_W) ? FW : fba_pkg::CFG_W;
	localparam int KBW   = (FW + 2 > fba_pkg::USED_KB_W) ? FW + 2 : fba_pkg::USED_KB_W;
	localparam int FRM_W = fba_pkg::ADDR_W - fba_pkg::PAGE_SHIFT;

	// Index of the lowest set bit of a byte.
	function automatic logic [2:0] lowest_set(input logic [7:0] v);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

	logic [fba_pkg::CFG_W-1:0]    frame_total_q;
	logic [fba_pkg::CFG_W-1:0]    reserved_q;
	logic [AW-1:0]                k_q;
	logic [FW-1:0]                rem_q;
	logic [FW-1:0]                count_q;
	logic [2:0]                   bit_q;
	logic                         oor_q;
	logic [fba_pkg::ADDR_W-1:0]   res_addr_q;
	logic [fba_pkg::STATUS_W-1:0] res_status_q;
	logic                         m_tvalid_q;
	logic [fba_pkg::ADDR_W-1:0]   out_addr_q;
	logic [fba_pkg::STATUS_W-1:0] out_status_q;
	logic [fba_pkg::USED_KB_W-1:0] out_kb_q;

	logic [FW-1:0]      limit;
	logic [FW-1:0]      n_sat;
	logic [FRM_W-1:0]   frm;
	logic [FRM_W-4:0]   frm_word;
	logic [AW-1:0]      free_word;
	logic               oor;
	logic               rem_gt8;
	logic               rem_ge8;
	logic [FW-1:0]      rem_next;
	logic [7:0]         mask;
	logic [7:0]         rd_data;
	logic [7:0]         free_bits;
	logic               found;
	logic [2:0]         pick;
	logic               last_word;
	logic               we;
	logic [7:0]         wdata;
	logic [AW-1:0]      raddr;
	logic [KBW-1:0]     kb_full;

	// Saturated frame count and reservation.
	assign limit = (CW'(frame_total_q) > CW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(frame_total_q);
	assign n_sat = (CW'(reserved_q) > CW'(MAX_FRAMES)) ? FW'(MAX_FRAMES) : FW'(reserved_q);

	// Frame of a free request; a word one past the map folds onto word zero.
	assign frm       = address[fba_pkg::ADDR_W-1:fba_pkg::PAGE_SHIFT];
	assign frm_word  = frm[FRM_W-1:3];
	assign free_word = (32'(frm_word) == 32'(DEPTH)) ? '0 : AW'(frm_word);
	assign oor       = 32'(frm) >= 32'(limit);

	// Frames of the current word that lie below the remaining count.
	assign rem_gt8  = rem_q > FW'(8);
	assign rem_ge8  = rem_q >= FW'(8);
	assign rem_next = rem_gt8 ? FW'(rem_q - FW'(8)) : '0;
	assign mask     = rem_ge8 ? 8'hff : 8'((9'd1 << rem_q[2:0]) - 9'd1);

	assign free_bits = ~rd_data & mask;
	assign found     = |free_bits;
	assign pick      = lowest_set(free_bits);
	assign last_word = k_q == AW'(DEPTH - 1);

	assign stat.sweep_last = last_word;
	assign stat.scan_found = found;
	assign stat.scan_end   = !found && (!rem_gt8 || last_word);
	assign stat.out_free   = !m_tvalid_q || m_tready;

	// Map memory access.
	always_comb begin
		we    = 1'b0;
		wdata = mask;
		if (cmd.sweep) begin
			we    = 1'b1;
			wdata = mask;
		end else if (cmd.scan) begin
			we    = found;
			wdata = rd_data | (8'd1 << pick);
		end else if (cmd.free_wr) begin
			we    = !oor_q;
			wdata = rd_data & ~(8'd1 << bit_q);
		end
	end

	always_comb begin
		if (cmd.start) begin
			raddr = (cmd.op == fba_pkg::OP_FREE) ? free_word : '0;
		end else if (cmd.scan && !found) begin
			raddr = AW'(k_q + 1'b1);
		end else begin
			raddr = k_q;
		end
	end

	fba_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_map (
		.clk  (clk),
		.we   (we),
		.waddr(k_q),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rd_data)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_total_q <= 13'd4096;
			reserved_q    <= 13'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fba_pkg::REG_FRAME_TOTAL: frame_total_q <= cfg_data;
				fba_pkg::REG_RESERVED:    reserved_q    <= cfg_data;
				default:                  frame_total_q <= frame_total_q;
			endcase
		end
	end

	// Word index, remaining frames and used count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q     <= '0;
			rem_q   <= '0;
			count_q <= '0;
		end else if (cmd.start) begin
			k_q   <= (cmd.op == fba_pkg::OP_FREE) ? free_word : '0;
			rem_q <= (cmd.op == fba_pkg::OP_INIT) ? n_sat : limit;
		end else if (cmd.sweep) begin
			k_q   <= AW'(k_q + 1'b1);
			rem_q <= rem_next;
			if (cmd.set_count) begin
				count_q <= n_sat;
			end
		end else if (cmd.scan) begin
			if (found) begin
				count_q <= FW'(count_q + 1'b1);
			end else begin
				k_q   <= AW'(k_q + 1'b1);
				rem_q <= rem_next;
			end
		end else if (cmd.free_wr) begin
			if (!oor_q && count_q != '0) begin
				count_q <= FW'(count_q - 1'b1);
			end
		end
	end

	// Per-request result registers.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			bit_q        <= frm[2:0];
			oor_q        <= oor;
			res_addr_q   <= '0;
			res_status_q <= fba_pkg::ST_OK;
		end else if (cmd.scan) begin
			if (found) begin
				res_addr_q <= 32'({k_q, pick, 12'd0});
			end else if (stat.scan_end) begin
				res_status_q <= fba_pkg::ST_NO_FRAME;
			end
		end else if (cmd.free_wr && oor_q) begin
			res_status_q <= fba_pkg::ST_RANGE;
		end
	end

	// Output register.
	assign kb_full = KBW'({count_q, 2'b00});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_addr_q   <= res_addr_q;
			out_status_q <= res_status_q;
			out_kb_q     <= kb_full[fba_pkg::USED_KB_W-1:0];
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {7'd0, out_kb_q, out_status_q, out_addr_q};

endmodule

// ===== tb/frame_bitmap_allocator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// frame_bitmap_allocator_unit_tb
// Self-checking bench for the first-fit frame allocator. A short table of
// directed requests and settings is followed by randomized phases under
// several frame counts and reservations. Each request predicts its result
// when it is accepted, and the result stream is checked in order.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator_unit_tb;

	localparam int MAX_FRAMES = 4096;
	localparam int MAP_WORDS = MAX_FRAMES / 8;
	localparam int HALF_PERIOD = 5;
	localparam int RESET_CYCLES = 9;
	// Every request produces a result, so the block is idle once the last
	// one has left. SETTLE_CYCLES adds margin before a settings change.
	localparam int SETTLE_CYCLES = 4;
	// An init or a full scan is the longest walk the controller takes.
	localparam int DRAIN_CYCLES = MAP_WORDS + 16;
	// The long receiver stall falls in the last phase, where no side idles.
	localparam int HOLD_AT_REQUEST = 1000;
	localparam int HOLD_CYCLES = 400;
	// The timeout lies well beyond the slowest correct run.
	localparam longint TIMEOUT = 40_000_000;
	localparam int NUM_DIRECTED = 28;
	localparam int NUM_PHASES = 6;
	localparam int RANDOM_REQUESTS = 1050;
	localparam logic TYPED = 1'b1;
	localparam logic PREDICTED = 1'b0;

	typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

	// Laid out exactly as the low bits of m_tdata.
	typedef struct packed {
		logic [fba_pkg::USED_KB_W-1:0] used_kb;
		logic [fba_pkg::STATUS_W-1:0]  status;
		logic [fba_pkg::ADDR_W-1:0]    frame_address;
	} alloc_result_t;

	// A request row uses op and addr; a settings row uses total and reserve.
	// The expected fields count only on request rows marked TYPED.
	typedef struct packed {
		row_kind_t                     kind;
		logic [fba_pkg::OP_W-1:0]      op;
		logic [fba_pkg::ADDR_W-1:0]    addr;
		logic [fba_pkg::CFG_W-1:0]     total;
		logic [fba_pkg::CFG_W-1:0]     reserve;
		logic                          typed;
		logic [fba_pkg::ADDR_W-1:0]    exp_addr;
		logic [fba_pkg::STATUS_W-1:0]  exp_status;
		logic [fba_pkg::USED_KB_W-1:0] exp_kb;
	} directed_row_t;

	typedef struct packed {
		logic [fba_pkg::CFG_W-1:0] total;
		logic [fba_pkg::CFG_W-1:0] reserve;
		logic [15:0]               requests;
	} phase_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [fba_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [fba_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           cfg_we = 1'b0;
	logic                           cfg_index = 1'b0;
	logic [fba_pkg::CFG_W-1:0]      cfg_data = '0;

	// Predicted allocator state: one flag per frame and the used count,
	// plus the settings as last written.
	bit                             frame_in_use [MAX_FRAMES];
	int unsigned                    used_frames = 0;
	logic [fba_pkg::CFG_W-1:0]      total_setting = 13'd4096;
	logic [fba_pkg::CFG_W-1:0]      reserve_setting = 13'd1;

	alloc_result_t                  expected_results [$];
	directed_row_t                  directed_rows [NUM_DIRECTED];
	phase_t                         phases [NUM_PHASES];
	int                             mismatches = 0;
	int                             requests_sent = 0;
	int                             sender_idle_pct = 0;
	int                             receiver_idle_pct = 0;
	int                             hold_left = 0;
	bit                             hold_done = 1'b0;

	always #(HALF_PERIOD) clk = ~clk;

	frame_bitmap_allocator_unit #(
		.MAX_FRAMES(MAX_FRAMES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Applies one request to the predicted state and returns its result.
	// Settings above the map size are clamped to the map size. The scan
	// simply looks for the lowest clear flag below the frame count, which
	// gives the same frame as a byte-skipping first-fit walk.
	function automatic alloc_result_t apply_request(input logic [fba_pkg::OP_W-1:0] op,
			input logic [fba_pkg::ADDR_W-1:0] addr);
		alloc_result_t res;
		int unsigned   limit;
		int unsigned   reserve;
		int unsigned   frame;
		res = '0;
		limit = (total_setting > MAX_FRAMES) ? MAX_FRAMES : total_setting;
		case (op)
			fba_pkg::OP_INIT: begin
				// Reserved frames are marked and counted even at or above
				// the frame count.
				reserve = (reserve_setting > MAX_FRAMES) ? MAX_FRAMES : reserve_setting;
				for (int f = 0; f < MAX_FRAMES; f++)
					frame_in_use[f] = (f < reserve);
				used_frames = reserve;
			end
			fba_pkg::OP_ALLOC: begin
				frame = 0;
				while (frame < limit && frame_in_use[frame])
					frame++;
				if (frame < limit) begin
					frame_in_use[frame] = 1'b1;
					used_frames++;
					res.frame_address = frame << fba_pkg::PAGE_SHIFT;
				end else begin
					res.status = fba_pkg::ST_NO_FRAME;
				end
			end
			fba_pkg::OP_FREE: begin
				frame = addr >> fba_pkg::PAGE_SHIFT;
				if (frame >= limit) begin
					res.status = fba_pkg::ST_RANGE;
				end else begin
					// A free of a clear frame still lowers the count,
					// which stops at zero.
					frame_in_use[frame] = 1'b0;
					if (used_frames > 0)
						used_frames--;
				end
			end
			fba_pkg::OP_NOP: ;
		endcase
		res.used_kb = fba_pkg::USED_KB_W'(used_frames * 4);
		return res;
	endfunction

	// Changes both settings while nothing is in flight.
	task automatic write_settings(input logic [fba_pkg::CFG_W-1:0] total,
			input logic [fba_pkg::CFG_W-1:0] reserve);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= fba_pkg::REG_FRAME_TOTAL;
		cfg_data <= total;
		@(posedge clk);
		cfg_index <= fba_pkg::REG_RESERVED;
		cfg_data <= reserve;
		@(posedge clk);
		cfg_we <= 1'b0;
		total_setting = total;
		reserve_setting = reserve;
	endtask

	// Offers one request, after an optional idle gap, and records what it
	// should produce once the transfer has happened. The valid stays high
	// across back-to-back requests.
	task automatic send_request(input logic [fba_pkg::OP_W-1:0] op,
			input logic [fba_pkg::ADDR_W-1:0] addr,
			input logic typed, input alloc_result_t typed_result);
		alloc_result_t predicted;
		int            gap;
		gap = 0;
		if ($urandom_range(99) < sender_idle_pct)
			gap = ($urandom_range(9) == 0) ? $urandom_range(40, 200) : $urandom_range(1, 12);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(fba_pkg::IN_DATA_W - fba_pkg::OP_W - fba_pkg::ADDR_W){1'b0}}, addr, op};
		do
			@(posedge clk);
		while (!s_tready);
		predicted = apply_request(op, addr);
		expected_results.push_back(typed ? typed_result : predicted);
		requests_sent++;
	endtask

	// Result side: random back-pressure, plus one long stall, counted here,
	// that lets the block fill up and stop taking requests.
	always @(posedge clk) begin
		if (!hold_done && requests_sent >= HOLD_AT_REQUEST) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= receiver_idle_pct);
		end
	end

	// Every result transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		alloc_result_t got;
		alloc_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata[$bits(alloc_result_t)-1:0];
			if (expected_results.size() == 0) begin
				$display("%0t: result with none expected: expected nothing, actual %h",
					$time, got);
				mismatches++;
			end else begin
				want = expected_results.pop_front();
				if (got.frame_address !== want.frame_address) begin
					$display("%0t: frame_address expected %h actual %h",
						$time, want.frame_address, got.frame_address);
					mismatches++;
				end
				if (got.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, got.status);
					mismatches++;
				end
				if (got.used_kb !== want.used_kb) begin
					$display("%0t: used_kb expected %0d actual %0d",
						$time, want.used_kb, got.used_kb);
					mismatches++;
				end
			end
		end
	end

	initial begin
		#(TIMEOUT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		logic [fba_pkg::OP_W-1:0]   op;
		logic [fba_pkg::ADDR_W-1:0] addr;
		int unsigned                limit;
		int unsigned                reserve;
		int unsigned                window;
		int                         pick;
		int                         random_index;

		// Directed part. After reset the map is empty, so the very first
		// allocation gets frame zero even before any init.
		directed_rows = '{
			'{ROW_REQ, fba_pkg::OP_ALLOC, 32'h0000_0000, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_OK, 15'd4},
			'{ROW_REQ, fba_pkg::OP_FREE, 32'h0000_0FFF, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_OK, 15'd0},
			// Freeing a clear frame with the count already at zero.
			'{ROW_REQ, fba_pkg::OP_FREE, 32'h0000_0000, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_FREE, 32'hFFFF_FFFF, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_RANGE, 15'd0},
			'{ROW_REQ, fba_pkg::OP_NOP, 32'hFFFF_FFFF, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_INIT, 32'hFFFF_FFFF, 13'd0, 13'd0,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_ALLOC, 32'h5A5A_5A5A, 13'd0, 13'd0,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_ALLOC, 32'h0000_0000, 13'd0, 13'd0,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_FREE, 32'h0000_1ABC, 13'd0, 13'd0,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			// First fit takes the hole just left.
			'{ROW_REQ, fba_pkg::OP_ALLOC, 32'hA5A5_A5A5, 13'd0, 13'd0,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			// Top frame is clear, yet the count still drops.
			'{ROW_REQ, fba_pkg::OP_FREE, 32'h00FF_F000, 13'd0, 13'd0,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_FREE, 32'h0100_0000, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_RANGE, 15'd8},
			// A tiny map with one frame left.
			'{ROW_CFG, fba_pkg::OP_NOP, 32'h0, 13'd16, 13'd15,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_INIT, 32'h0000_0000, 13'd0, 13'd0,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_ALLOC, 32'h0000_0000, 13'd0, 13'd0,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_ALLOC, 32'h0000_0000, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_NO_FRAME, 15'd64},
			'{ROW_REQ, fba_pkg::OP_FREE, 32'h0001_0000, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_RANGE, 15'd64},
			// No frames managed at all.
			'{ROW_CFG, fba_pkg::OP_NOP, 32'h0, 13'd0, 13'd15,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_ALLOC, 32'h0000_0000, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_NO_FRAME, 15'd64},
			'{ROW_REQ, fba_pkg::OP_FREE, 32'h0000_0000, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_RANGE, 15'd64},
			// Both settings above the map size saturate to it.
			'{ROW_CFG, fba_pkg::OP_NOP, 32'h0, 13'd8191, 13'd8191,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_INIT, 32'h0000_0000, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_OK, 15'd16384},
			'{ROW_REQ, fba_pkg::OP_ALLOC, 32'h0000_0000, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_NO_FRAME, 15'd16384},
			'{ROW_REQ, fba_pkg::OP_FREE, 32'h00FF_FFFF, 13'd0, 13'd0,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_ALLOC, 32'h0000_0000, 13'd0, 13'd0,
				TYPED, 32'h00FF_F000, fba_pkg::ST_OK, 15'd16384},
			// Nothing reserved: frame zero is handed out like any other.
			'{ROW_CFG, fba_pkg::OP_NOP, 32'h0, 13'd4096, 13'd0,
				PREDICTED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_INIT, 32'h0000_0000, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_OK, 15'd0},
			'{ROW_REQ, fba_pkg::OP_ALLOC, 32'h0000_0000, 13'd0, 13'd0,
				TYPED, 32'h0, fba_pkg::ST_OK, 15'd4}
		};

		// Random phases: frame count, reservation and number of requests.
		// The third phase reserves more frames than it manages.
		phases = '{
			'{13'd4096, 13'd1, 16'd300},
			'{13'd37, 13'd5, 16'd250},
			'{13'd200, 13'd300, 16'd150},
			'{13'd1, 13'd0, 16'd100},
			'{13'd4096, 13'd4000, 16'd150},
			'{13'd64, 13'd64, 16'd100}
		};

		sender_idle_pct = 12;
		receiver_idle_pct = 60;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// The first request waits out the clearing pass on s_tready.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				write_settings(directed_rows[i].total, directed_rows[i].reserve);
			end else begin
				send_request(directed_rows[i].op, directed_rows[i].addr, directed_rows[i].typed,
					alloc_result_t'{directed_rows[i].exp_kb, directed_rows[i].exp_status,
						directed_rows[i].exp_addr});
			end
		end

		random_index = 0;
		foreach (phases[p]) begin
			write_settings(phases[p].total, phases[p].reserve);
			limit = (total_setting > MAX_FRAMES) ? MAX_FRAMES : total_setting;
			reserve = (reserve_setting > MAX_FRAMES) ? MAX_FRAMES : reserve_setting;
			for (int n = 0; n < phases[p].requests; n++) begin
				// Idling shifts from the receiver being quiet, to the sender
				// being quiet, to neither.
				if (random_index == RANDOM_REQUESTS / 3) begin
					sender_idle_pct = 60;
					receiver_idle_pct = 12;
				end else if (random_index == 2 * RANDOM_REQUESTS / 3) begin
					sender_idle_pct = 0;
					receiver_idle_pct = 0;
				end
				pick = $urandom_range(99);
				addr = $urandom;
				if (n == 0 || pick < 2) begin
					// Each phase starts from a freshly built map.
					op = fba_pkg::OP_INIT;
				end else if (pick < 47) begin
					op = fba_pkg::OP_ALLOC;
				end else if (pick < 80) begin
					// Frees mostly land on managed frames, and half of them
					// near the bottom, where first fit puts allocations.
					op = fba_pkg::OP_FREE;
					if (limit > 0) begin
						window = (pick < 64 && reserve + 64 < limit) ? reserve + 64 : limit;
						addr = ($urandom_range(window - 1) << fba_pkg::PAGE_SHIFT)
							| $urandom_range(4095);
					end
				end else if (pick < 90) begin
					op = fba_pkg::OP_FREE;
				end else if (pick < 95) begin
					// At the frame count or just past it, outside the managed frames.
					op = fba_pkg::OP_FREE;
					addr = ((limit + $urandom_range(3)) << fba_pkg::PAGE_SHIFT)
						| $urandom_range(4095);
				end else begin
					op = fba_pkg::OP_NOP;
				end
				send_request(op, addr, PREDICTED, '0);
				random_index++;
			end
		end

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		// Any stray result would show up within one more long walk.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
